// File: sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types and constants for the spray pulse sequencer: the payload structures,
// the phase codes, the configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int unsigned ClockWidth = 32;
    localparam int unsigned MsWidth    = 16;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned CfgIdxWidth = 4;

    typedef struct packed {
        logic [MsWidth-1:0]    elapsed_ms;
        logic                  run_step;
        logic                  cancel;
        logic [CountWidth-1:0] pulses_wanted;
    } spray_in_t;

    typedef struct packed {
        logic motor_a;
        logic motor_b;
        logic done_res;
        logic busy_res;
    } spray_out_t;

    typedef enum logic [2:0] {
        PH_FWD_START = 3'd0,
        PH_FWD       = 3'd1,
        PH_BRAKE     = 3'd2,
        PH_REV       = 3'd3,
        PH_REST      = 3'd4
    } phase_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_ON_MS      = 4'd0,
        CFG_PAUSE1_MS  = 4'd1,
        CFG_REVERSE_MS = 4'd2,
        CFG_PAUSE2_MS  = 4'd3
    } cfg_index_t;

    localparam logic [MsWidth-1:0] OnMsReset      = 16'd300;
    localparam logic [MsWidth-1:0] Pause1MsReset  = 16'd200;
    localparam logic [MsWidth-1:0] ReverseMsReset = 16'd300;
    localparam logic [MsWidth-1:0] Pause2MsReset  = 16'd1000;

    localparam logic [1:0] DriveOff     = 2'b00;
    localparam logic [1:0] DriveForward = 2'b01;
    localparam logic [1:0] DriveReverse = 2'b10;

endpackage

// File: sv/spray_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// spray_pulse_sequencer
// H-bridge sequencer for a spray actuator: forward drive, brake, reverse
// drive and rest between pulses, timed against a millisecond clock.
// ----------------------------------------------------------------------------
//  channel  | ports                              | payload
//  ---------+------------------------------------+---------------------------
//  input    | s_valid, s_ready, s_data           | sps_pkg::spray_in_t
//  result   | m_valid, m_ready, m_data           | sps_pkg::spray_out_t
//  config   | cfg_valid, cfg_ready, cfg_index,   | 16-bit register value
//           | cfg_data                           |
//
// One transaction per cycle is sustained while m_ready does not stall the result;
// a result is presented on m_valid after its input passes the input register,
// then the result register. The rate is set by the state update of the sequencer.
// Reset is synchronous and active low; it restores the idle state and the
// default timings. A stalled result holds the result register, and the input
// register keeps accepting until it is full as well.
// ----------------------------------------------------------------------------
module spray_pulse_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sps_pkg::spray_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sps_pkg::spray_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sps_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [sps_pkg::MsWidth-1:0]         cfg_data
);

    logic [sps_pkg::MsWidth-1:0]    on_ms_reg;
    logic [sps_pkg::MsWidth-1:0]    pause1_ms_reg;
    logic [sps_pkg::MsWidth-1:0]    reverse_ms_reg;
    logic [sps_pkg::MsWidth-1:0]    pause2_ms_reg;

    logic                           in_valid_reg;
    sps_pkg::spray_in_t             in_data_reg;
    logic                           out_valid_reg;
    sps_pkg::spray_out_t            out_data_reg;
    sps_pkg::spray_out_t            out_data_next;

    sps_pkg::phase_t                phase_reg;
    sps_pkg::phase_t                phase_next;
    logic [sps_pkg::CountWidth-1:0] pulse_index_reg;
    logic [sps_pkg::CountWidth-1:0] pulse_index_next;
    logic [sps_pkg::CountWidth-1:0] pulse_target_reg;
    logic [sps_pkg::CountWidth-1:0] pulse_target_next;
    logic                           active_reg;
    logic                           active_next;
    logic [sps_pkg::ClockWidth-1:0] clock_now_reg;
    logic [sps_pkg::ClockWidth-1:0] clock_now_next;
    logic [sps_pkg::ClockWidth-1:0] phase_mark_reg;
    logic [sps_pkg::ClockWidth-1:0] phase_mark_next;
    logic [1:0]                     drive_reg;
    logic [1:0]                     drive_next;

    logic                           advance;
    logic                           done;
    logic                           expired;
    logic [sps_pkg::MsWidth-1:0]    span;
    logic [sps_pkg::ClockWidth-1:0] since_mark;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_ms_reg      <= sps_pkg::OnMsReset;
            pause1_ms_reg  <= sps_pkg::Pause1MsReset;
            reverse_ms_reg <= sps_pkg::ReverseMsReset;
            pause2_ms_reg  <= sps_pkg::Pause2MsReset;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sps_pkg::CFG_ON_MS:      on_ms_reg      <= cfg_data;
                sps_pkg::CFG_PAUSE1_MS:  pause1_ms_reg  <= cfg_data;
                sps_pkg::CFG_REVERSE_MS: reverse_ms_reg <= cfg_data;
                sps_pkg::CFG_PAUSE2_MS:  pause2_ms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_comb begin
        case (phase_reg)
            sps_pkg::PH_FWD:   span = on_ms_reg;
            sps_pkg::PH_BRAKE: span = pause1_ms_reg;
            sps_pkg::PH_REV:   span = reverse_ms_reg;
            sps_pkg::PH_REST:  span = pause2_ms_reg;
            default:           span = '0;
        endcase
    end

    assign clock_now_next = clock_now_reg
                          + {{(sps_pkg::ClockWidth-sps_pkg::MsWidth){1'b0}},
                             in_data_reg.elapsed_ms};
    assign since_mark     = clock_now_next - phase_mark_reg;
    assign expired        = since_mark
                          >= {{(sps_pkg::ClockWidth-sps_pkg::MsWidth){1'b0}}, span};

    always_comb begin
        phase_next        = phase_reg;
        pulse_index_next  = pulse_index_reg;
        pulse_target_next = pulse_target_reg;
        active_next       = active_reg;
        phase_mark_next   = phase_mark_reg;
        drive_next        = drive_reg;
        done              = 1'b0;
        if (in_data_reg.cancel) begin
            phase_next       = sps_pkg::PH_FWD_START;
            pulse_index_next = '0;
            active_next      = 1'b0;
            phase_mark_next  = '0;
            drive_next       = sps_pkg::DriveOff;
        end else if (in_data_reg.run_step) begin
            if (!active_reg) begin
                active_next       = 1'b1;
                pulse_target_next = (in_data_reg.pulses_wanted == '0)
                                  ? sps_pkg::CountWidth'(1) : in_data_reg.pulses_wanted;
            end
            case (phase_reg)
                sps_pkg::PH_FWD: begin
                    if (expired) begin
                        phase_next      = sps_pkg::PH_BRAKE;
                        phase_mark_next = clock_now_next;
                        drive_next      = sps_pkg::DriveOff;
                    end
                end
                sps_pkg::PH_BRAKE: begin
                    if (expired) begin
                        phase_next      = sps_pkg::PH_REV;
                        phase_mark_next = clock_now_next;
                        drive_next      = sps_pkg::DriveReverse;
                    end
                end
                sps_pkg::PH_REV: begin
                    if (expired) begin
                        drive_next = sps_pkg::DriveOff;
                        if ({1'b0, pulse_index_reg} + 5'd1 < {1'b0, pulse_target_next}) begin
                            phase_next      = sps_pkg::PH_REST;
                            phase_mark_next = clock_now_next;
                        end else begin
                            phase_next       = sps_pkg::PH_FWD_START;
                            pulse_index_next = '0;
                            active_next      = 1'b0;
                            phase_mark_next  = '0;
                            done             = 1'b1;
                        end
                    end
                end
                sps_pkg::PH_REST: begin
                    if (expired) begin
                        pulse_index_next = pulse_index_reg + sps_pkg::CountWidth'(1);
                        phase_next       = sps_pkg::PH_FWD_START;
                        phase_mark_next  = clock_now_next;
                    end
                end
                default: begin
                    phase_next      = sps_pkg::PH_FWD;
                    phase_mark_next = clock_now_next;
                    drive_next      = sps_pkg::DriveForward;
                end
            endcase
        end
    end

    always_comb begin
        out_data_next.motor_a  = drive_next[0];
        out_data_next.motor_b  = drive_next[1];
        out_data_next.done_res = done;
        out_data_next.busy_res = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= sps_pkg::PH_FWD_START;
            pulse_index_reg  <= '0;
            pulse_target_reg <= '0;
            active_reg       <= 1'b0;
            clock_now_reg    <= '0;
            phase_mark_reg   <= '0;
            drive_reg        <= sps_pkg::DriveOff;
        end else if (advance) begin
            phase_reg        <= phase_next;
            pulse_index_reg  <= pulse_index_next;
            pulse_target_reg <= pulse_target_next;
            active_reg       <= active_next;
            clock_now_reg    <= clock_now_next;
            phase_mark_reg   <= phase_mark_next;
            drive_reg        <= drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done reported while still busy");

    a_no_shoot_through: assert property (@(posedge aclk) disable iff (!aresetn)
        !(drive_reg[0] && drive_reg[1]))
        else $error("both bridge inputs driven high");

    a_idle_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> phase_reg == sps_pkg::PH_FWD_START && pulse_index_reg == '0)
        else $error("idle sequencer holds a stale phase or pulse index");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> pulse_index_reg < pulse_target_reg)
        else $error("pulse index reached the pulse target while active");
`endif

endmodule
